// ===== rtl/gas_pkg.sv =====
// Shared constants, codes and control types of the goal approach supervisor.
package gas_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_XY_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MAX = 3'd5;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  localparam logic [2:0] PH_OUTSIDE  = 3'd0;
  localparam logic [2:0] PH_APPROACH = 3'd1;
  localparam logic [2:0] PH_ALIGN    = 3'd2;
  localparam logic [2:0] PH_REACHED  = 3'd3;
  localparam logic [2:0] PH_TIMEOUT  = 3'd4;

  // operand pairs for the squared-distance unit
  localparam logic [1:0] SEL_RAM_ROBOT  = 2'd0;
  localparam logic [1:0] SEL_RAM_PREV   = 2'd1;
  localparam logic [1:0] SEL_PREV_ROBOT = 2'd2;

  localparam logic [4:0] LAST_TERM    = 5'd5;
  localparam logic [4:0] LAST_SQ_STEP = 5'd31;

  // square of the largest 32-bit root; at or above it the root reads as all ones
  localparam logic [65:0] SQ_SAT = 66'h0_FFFF_FFFE_0000_0001;

  localparam logic signed [16:0] PI_Q     = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q = 17'sd51472;

  typedef struct packed {
    logic             clr_path;
    logic             append;
    logic             rst_latch;
    logic             step_ld;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             ld_ops;
    logic [1:0]       ld_sel;
    logic             prev_ld;
    logic             mul_go;
    logic [2:0]       term;
    logic             best_ld;
    logic             arc_clr;
    logic             sq_ld;
    logic             sq_spd;
    logic             sq_step;
    logic             arc_add;
    logic             dist_ld;
    logic             speed_ld;
    logic             herr_ld;
    logic             spmul;
    logic             out_ld;
  } gas_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             closer;
    logic             need_speed;
  } gas_sts_t;

endpackage

// ===== rtl/gas_in_if.sv =====
// Input channel: command beat with pose or path point.
interface gas_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic [15:0]        dt_us;

  modport source (output valid, cmd, pos_x, pos_y, heading, dt_us, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, heading, dt_us, output ready);
endinterface

// ===== rtl/gas_out_if.sv =====
// Result channel: one supervisor report beat per control step.
interface gas_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic [31:0]        speed_limit;
  logic signed [31:0] turn_command;
  logic [31:0]        arc_left;
  logic [31:0]        distance_error;
  logic signed [15:0] heading_error;
  logic [31:0]        align_time;

  modport source (output valid, phase, speed_limit, turn_command, arc_left,
                  distance_error, heading_error, align_time, input ready);
  modport sink   (input valid, phase, speed_limit, turn_command, arc_left,
                  distance_error, heading_error, align_time, output ready);
endinterface

// ===== rtl/gas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gas_ctrl.sv =====
// Sequencer: walks the path store and drives the shared multiply and root units.
module gas_ctrl
  import gas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  gas_sts_t   sts,
  output gas_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_LD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_NCMP  = 4'd5;
  localparam logic [3:0] S_SQLD  = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;
  localparam logic [3:0] S_DEC   = 4'd9;
  localparam logic [3:0] S_SPMUL = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  localparam logic [2:0] JOB_NEAR  = 3'd0;
  localparam logic [2:0] JOB_ARCP  = 3'd1;
  localparam logic [2:0] JOB_ARC   = 3'd2;
  localparam logic [2:0] JOB_GOAL  = 3'd3;
  localparam logic [2:0] JOB_SPEED = 3'd4;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       job_r, job_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] best_i_r, best_i_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0] i_inc;
  logic             more;

  assign i_inc = i_r + CNT_W'(1);
  assign more  = i_inc < sts.count;

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    best_i_nxt = best_i_r;
    cmd        = '0;
    cmd.rd_addr = i_r[IDX_W-1:0];
    cmd.term    = cnt_r[2:0];
    cmd.sq_spd  = (job_r == JOB_SPEED);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_CLEAR:  cmd.clr_path  = 1'b1;
            CMD_APPEND: cmd.append    = 1'b1;
            CMD_RESET:  cmd.rst_latch = 1'b1;
            CMD_STEP: begin
              cmd.step_ld = 1'b1;
              i_nxt       = '0;
              job_nxt     = JOB_NEAR;
              state_nxt   = (sts.count == '0) ? S_DEC : S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cnt_nxt = '0;
        unique case (job_r)
          JOB_NEAR: begin
            cmd.ld_ops = 1'b1;
            cmd.ld_sel = SEL_RAM_ROBOT;
            state_nxt  = S_MUL;
          end
          JOB_ARCP: begin
            cmd.prev_ld = 1'b1;
            i_nxt       = i_inc;
            job_nxt     = more ? JOB_ARC : JOB_GOAL;
            state_nxt   = more ? S_RD : S_LD;
          end
          JOB_ARC: begin
            cmd.ld_ops  = 1'b1;
            cmd.ld_sel  = SEL_RAM_PREV;
            cmd.prev_ld = 1'b1;
            state_nxt   = S_MUL;
          end
          default: begin
            cmd.ld_ops = 1'b1;
            cmd.ld_sel = SEL_PREV_ROBOT;
            state_nxt  = S_MUL;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == LAST_TERM) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = (job_r == JOB_NEAR) ? S_NCMP : S_SQLD;
      end
      S_NCMP: begin
        if (i_r == '0 || sts.closer) begin
          cmd.best_ld = 1'b1;
          best_i_nxt  = i_r[IDX_W-1:0];
        end
        state_nxt = S_RD;
        if (more) begin
          i_nxt = i_inc;
        end else begin
          cmd.arc_clr = 1'b1;
          i_nxt       = {1'b0, best_i_nxt};
          job_nxt     = JOB_ARCP;
        end
      end
      S_SQLD: begin
        cmd.sq_ld = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 5'd1;
        if (cnt_r == LAST_SQ_STEP) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        unique case (job_r)
          JOB_ARC: begin
            cmd.arc_add = 1'b1;
            i_nxt       = i_inc;
            job_nxt     = more ? JOB_ARC : JOB_GOAL;
            state_nxt   = more ? S_RD : S_LD;
          end
          JOB_GOAL: begin
            cmd.dist_ld = 1'b1;
            state_nxt   = S_DEC;
          end
          default: begin
            cmd.speed_ld = 1'b1;
            state_nxt    = S_FIN;
          end
        endcase
      end
      S_DEC: begin
        cmd.herr_ld = 1'b1;
        state_nxt   = sts.need_speed ? S_SPMUL : S_FIN;
      end
      S_SPMUL: begin
        cmd.spmul = 1'b1;
        job_nxt   = JOB_SPEED;
        state_nxt = S_SQLD;
      end
      S_FIN: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_ld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      job_r     <= JOB_NEAR;
      i_r       <= '0;
      cnt_r     <= '0;
      best_i_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      job_r     <= job_nxt;
      i_r       <= i_nxt;
      cnt_r     <= cnt_nxt;
      best_i_r  <= best_i_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

endmodule

// ===== rtl/gas_dp.sv =====
// Datapath: path store, squared distance, bit-serial root, phase decision.
module gas_dp
  import gas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  gas_cmd_t              cmd,
  output gas_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [15:0]    heading,
  input  logic [15:0]           dt_us,
  output logic [2:0]            phase,
  output logic [31:0]           speed_limit,
  output logic signed [31:0]    turn_command,
  output logic [31:0]           arc_left,
  output logic [31:0]           distance_error,
  output logic signed [15:0]    heading_error,
  output logic [31:0]           align_time
);

  // configuration
  logic [31:0] xy_tol_r, band_r, decel_r, tmo_r;
  logic [14:0] head_tol_r;
  logic [30:0] turn_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_tol_r   <= 32'd16384;
      head_tol_r <= 15'd1430;
      band_r     <= 32'd65536;
      decel_r    <= 32'd32768;
      tmo_r      <= 32'd5000000;
      turn_max_r <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_XY_TOL:   xy_tol_r   <= cfg_data;
        CFG_HEAD_TOL: head_tol_r <= cfg_data[14:0];
        CFG_BAND:     band_r     <= cfg_data;
        CFG_DECEL:    decel_r    <= cfg_data;
        CFG_TIMEOUT:  tmo_r      <= cfg_data;
        CFG_TURN_MAX: turn_max_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // path store
  logic [CNT_W-1:0]   count_r;
  logic signed [15:0] goal_yaw_r;
  logic               wr_en;
  logic [31:0]        ram_x, ram_y;

  assign wr_en = cmd.append && (count_r < CNT_W'(MAX_POINTS));

  gas_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(pos_x),
    .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(ram_x)
  );

  gas_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(wr_en), .waddr(count_r[IDX_W-1:0]), .wdata(pos_y),
    .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(ram_y)
  );

  // step inputs and operands
  logic [31:0] rx_r, ry_r, prev_x_r, prev_y_r;
  logic [15:0] yaw_r, dt_r;
  logic [31:0] opa_x, opa_y, opb_x, opb_y;
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  logic [31:0] ux_r, uy_r;

  always_comb begin
    case (cmd.ld_sel)
      SEL_RAM_PREV: begin
        opa_x = ram_x;    opa_y = ram_y;
        opb_x = prev_x_r; opb_y = prev_y_r;
      end
      SEL_PREV_ROBOT: begin
        opa_x = prev_x_r; opa_y = prev_y_r;
        opb_x = rx_r;     opb_y = ry_r;
      end
      default: begin
        opa_x = ram_x; opa_y = ram_y;
        opb_x = rx_r;  opb_y = ry_r;
      end
    endcase
    dx = $signed({opa_x[31], opa_x}) - $signed({opb_x[31], opb_x});
    dy = $signed({opa_y[31], opa_y}) - $signed({opb_y[31], opb_y});
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
  end

  // squared distance: six 16x16 partial products, one per cycle
  logic [15:0] ma, mb;
  logic [5:0]  msh;
  logic [31:0] pp_r;
  logic [5:0]  pp_sh_r;
  logic        pp_vld_r;
  logic [65:0] acc_r, best_r;

  always_comb begin
    case (cmd.term)
      3'd0:    begin ma = ux_r[15:0];  mb = ux_r[15:0];  msh = 6'd0;  end
      3'd1:    begin ma = ux_r[15:0];  mb = ux_r[31:16]; msh = 6'd17; end
      3'd2:    begin ma = ux_r[31:16]; mb = ux_r[31:16]; msh = 6'd32; end
      3'd3:    begin ma = uy_r[15:0];  mb = uy_r[15:0];  msh = 6'd0;  end
      3'd4:    begin ma = uy_r[15:0];  mb = uy_r[31:16]; msh = 6'd17; end
      3'd5:    begin ma = uy_r[31:16]; mb = uy_r[31:16]; msh = 6'd32; end
      default: begin ma = '0;          mb = '0;          msh = 6'd0;  end
    endcase
  end

  // bit-serial root, two radicand bits per step
  logic [65:0] sq_val;
  logic [63:0] sq_in_r;
  logic        sq_sat_r;
  logic [35:0] rem_r, rem_sh, trial;
  logic [31:0] root_r, sq_res;
  logic [63:0] prod_r;

  assign sq_val = cmd.sq_spd ? {1'b0, prod_r, 1'b0} : acc_r;
  assign rem_sh = {rem_r[33:0], sq_in_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign sq_res = sq_sat_r ? '1 : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= cmd.mul_go;
    end
  end

  logic [32:0] arc_sum;
  logic [31:0] arc_r, dist_r, speed_r;

  assign arc_sum = {1'b0, arc_r} + {1'b0, sq_res};

  always_ff @(posedge clk) begin
    if (cmd.step_ld) begin
      rx_r  <= pos_x;
      ry_r  <= pos_y;
      yaw_r <= heading;
      dt_r  <= dt_us;
    end
    if (cmd.prev_ld) begin
      prev_x_r <= ram_x;
      prev_y_r <= ram_y;
    end
    if (cmd.ld_ops) begin
      ux_r <= ax[31:0];
      uy_r <= ay[31:0];
    end
    pp_r    <= ma * mb;
    pp_sh_r <= msh;
    if (cmd.ld_ops) begin
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + ({34'd0, pp_r} << pp_sh_r);
    end
    if (cmd.best_ld) begin
      best_r <= acc_r;
    end
    if (cmd.sq_ld) begin
      sq_sat_r <= (sq_val >= SQ_SAT);
      sq_in_r  <= sq_val[63:0];
      rem_r    <= '0;
      root_r   <= '0;
    end else if (cmd.sq_step) begin
      sq_in_r <= {sq_in_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.step_ld) begin
      arc_r <= '1;
    end else if (cmd.arc_clr) begin
      arc_r <= '0;
    end else if (cmd.arc_add) begin
      arc_r <= arc_sum[32] ? '1 : arc_sum[31:0];
    end
    if (cmd.step_ld) begin
      dist_r <= '0;
    end else if (cmd.dist_ld) begin
      dist_r <= sq_res;
    end
    if (cmd.speed_ld) begin
      speed_r <= sq_res;
    end
    if (cmd.spmul) begin
      prod_r <= decel_r * arc_r;
    end
  end

  // heading error, one wrap either way covers every 16-bit input pair
  logic signed [16:0] hd, hw;
  logic signed [15:0] herr_r;

  always_comb begin
    hd = $signed({goal_yaw_r[15], goal_yaw_r}) - $signed({yaw_r[15], yaw_r});
    if (hd > PI_Q) begin
      hw = hd - TWO_PI_Q;
    end else if (hd <= -PI_Q) begin
      hw = hd + TWO_PI_Q;
    end else begin
      hw = hd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.herr_ld) begin
      herr_r <= (count_r == '0) ? 16'sd0 : hw[15:0];
    end
  end

  // phase decision
  logic               latch_r, latch_to_r;
  logic [31:0]        timer_r;
  logic               latch_nxt, latch_to_nxt;
  logic [31:0]        timer_nxt;
  logic [2:0]         ph_nxt;
  logic [31:0]        spd_nxt, at_nxt;
  logic signed [31:0] turn_nxt;
  logic [15:0]        mag;
  logic [32:0]        tsum;
  logic [31:0]        tnew;
  logic signed [32:0] t33, lim;

  assign mag  = herr_r[15] ? 16'(-herr_r) : 16'(herr_r);
  assign tsum = {1'b0, timer_r} + {17'd0, dt_r};
  assign tnew = tsum[32] ? '1 : tsum[31:0];
  assign t33  = {{13{herr_r[15]}}, herr_r, 4'b0000};
  assign lim  = $signed({2'b00, turn_max_r});

  assign sts.count      = count_r;
  assign sts.closer     = acc_r < best_r;
  assign sts.need_speed = !latch_r && (count_r != '0) && (arc_r <= band_r)
                          && (dist_r > xy_tol_r);

  always_comb begin
    ph_nxt       = PH_OUTSIDE;
    spd_nxt      = '1;
    turn_nxt     = '0;
    at_nxt       = '0;
    latch_nxt    = latch_r;
    latch_to_nxt = latch_to_r;
    timer_nxt    = timer_r;
    if (latch_r) begin
      ph_nxt  = latch_to_r ? PH_TIMEOUT : PH_REACHED;
      spd_nxt = '0;
      at_nxt  = timer_r;
    end else if (count_r == '0 || arc_r > band_r) begin
      timer_nxt = '0;
    end else if (dist_r > xy_tol_r) begin
      timer_nxt = '0;
      ph_nxt    = PH_APPROACH;
      spd_nxt   = speed_r;
    end else begin
      spd_nxt = '0;
      if (mag <= {1'b0, head_tol_r}) begin
        timer_nxt    = '0;
        latch_nxt    = 1'b1;
        latch_to_nxt = 1'b0;
        ph_nxt       = PH_REACHED;
      end else begin
        timer_nxt = tnew;
        at_nxt    = tnew;
        if (tnew > tmo_r) begin
          latch_nxt    = 1'b1;
          latch_to_nxt = 1'b1;
          ph_nxt       = PH_TIMEOUT;
        end else begin
          ph_nxt = PH_ALIGN;
          if (t33 > lim) begin
            turn_nxt = lim[31:0];
          end else if (t33 < -lim) begin
            turn_nxt = 32'(-lim);
          end else begin
            turn_nxt = t33[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      goal_yaw_r <= '0;
      latch_r    <= 1'b0;
      latch_to_r <= 1'b0;
      timer_r    <= '0;
    end else begin
      if (cmd.clr_path) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r    <= count_r + CNT_W'(1);
        goal_yaw_r <= heading;
      end
      if (cmd.rst_latch) begin
        latch_r    <= 1'b0;
        latch_to_r <= 1'b0;
        timer_r    <= '0;
      end else if (cmd.out_ld) begin
        latch_r    <= latch_nxt;
        latch_to_r <= latch_to_nxt;
        timer_r    <= timer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      phase          <= ph_nxt;
      speed_limit    <= spd_nxt;
      turn_command   <= turn_nxt;
      arc_left       <= arc_r;
      distance_error <= dist_r;
      heading_error  <= herr_r;
      align_time     <= at_nxt;
    end
  end

endmodule

// ===== rtl/goal_approach_supervisor.sv =====
// Top level of the goal approach supervisor: sequencer, datapath and checks.
//
// Path points arrive on the input channel as append beats (cmd 1) and sit in
// two 256-entry RAMs; cmd 0 empties the path, cmd 3 clears the arrival latch
// and the alignment timer, and none of these gives a result. A control step
// (cmd 2) gives one result beat. The nearest-point scan runs each point
// through the shared squared-distance unit (one 16x16 multiplier, six partial
// products), and each arc segment after the nearest point, the goal distance
// and, when one is needed, the approach speed cap each add a pass through the
// bit-serial square root. An empty path skips the scan and the root passes.
// Input is taken only between steps; the finished report waits in the output
// register while new beats are taken, and a step that ends while the previous
// report is still held waits there. Configuration writes are taken at any time
// but are meant for idle periods.
module goal_approach_supervisor
  import gas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  gas_in_if.sink                in_ch,
  gas_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gas_cmd_t cmd;
  gas_sts_t sts;

  // control: beat acceptance, scan order, unit sequencing
  gas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: store, arithmetic units, latch and timer, report register
  gas_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .pos_x          (in_ch.pos_x),
    .pos_y          (in_ch.pos_y),
    .heading        (in_ch.heading),
    .dt_us          (in_ch.dt_us),
    .phase          (out_ch.phase),
    .speed_limit    (out_ch.speed_limit),
    .turn_command   (out_ch.turn_command),
    .arc_left       (out_ch.arc_left),
    .distance_error (out_ch.distance_error),
    .heading_error  (out_ch.heading_error),
    .align_time     (out_ch.align_time)
  );

  // a non-step beat never produces a report
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd != CMD_STEP && !out_ch.valid)
      |=> !out_ch.valid)
    else $error("report raised by a non-step beat");

  // turn command only while aligning
  a_turn_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.phase != PH_ALIGN) |-> (out_ch.turn_command == '0))
    else $error("turn command outside alignment");

  // latched phases hold the robot
  a_latched_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.phase == PH_REACHED || out_ch.phase == PH_TIMEOUT))
      |-> (out_ch.speed_limit == '0))
    else $error("nonzero speed in a latched phase");

  // no input taken while a step is in progress
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_STEP && sts.count != '0)
      |=> !in_ch.ready)
    else $error("input taken during a step");

endmodule

// ===== sim/gas_tb_pkg.sv =====
// Scoreboard class that predicts supervisor reports and checks result beats.
package gas_tb_pkg;
  import gas_pkg::*;

  typedef struct packed {
    logic [2:0]         phase;
    logic [31:0]        speed_limit;
    logic signed [31:0] turn_command;
    logic [31:0]        arc_left;
    logic [31:0]        distance_error;
    logic signed [15:0] heading_error;
    logic [31:0]        align_time;
  } report_t;

  class approach_scoreboard;
    bit [31:0] xy_tol, band, decel, timeout_us;
    bit [14:0] head_tol;
    bit [30:0] turn_max;
    bit [31:0] xs[MAX_POINTS];
    bit [31:0] ys[MAX_POINTS];
    int        npts;
    bit signed [15:0] goal_yaw;
    bit        latched, latched_timeout;
    bit [31:0] timer;
    report_t   pending[$];
    int        errors;
    int        checked;
    int        phase_seen[5];

    function new();
      xy_tol = 16384; head_tol = 1430; band = 65536; decel = 32768;
      timeout_us = 5000000; turn_max = 65536;
      npts = 0; goal_yaw = 0; latched = 0; latched_timeout = 0; timer = 0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
        CFG_XY_TOL:   xy_tol = v;
        CFG_HEAD_TOL: head_tol = v[14:0];
        CFG_BAND:     band = v;
        CFG_DECEL:    decel = v;
        CFG_TIMEOUT:  timeout_us = v;
        CFG_TURN_MAX: turn_max = v[30:0];
        default: ;
      endcase
    endfunction

    // floor root of a 66-bit square, saturated to 32 bits
    function bit [31:0] root_sat(bit [65:0] n);
      bit [65:0] r, b;
      if (n >= {2'b0, 64'hFFFF_FFFE_0000_0001}) return '1;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
        b = r | (66'd1 << k);
        if (b * b <= n) r = b;
      end
      return r[31:0];
    endfunction

    function bit [65:0] sq_dist(bit [31:0] ax, bit [31:0] ay, bit [31:0] bx, bit [31:0] by);
      longint dx, dy;
      bit [65:0] ux, uy;
      dx = longint'($signed(ax)) - longint'($signed(bx));
      dy = longint'($signed(ay)) - longint'($signed(by));
      ux = 66'(dx < 0 ? -dx : dx);
      uy = 66'(dy < 0 ? -dy : dy);
      return ux * ux + uy * uy;
    endfunction

    function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = a + b;
      return s[32] ? '1 : s[31:0];
    endfunction

    function void note_input(logic [1:0] cmd, bit [31:0] px, bit [31:0] py,
                             bit signed [15:0] yaw, bit [15:0] dt);
      report_t r;
      bit [65:0] best_sq, d;
      int best;
      int herr, mag;
      longint turn;
      bit [65:0] prod;
      case (cmd)
        CMD_CLEAR: begin npts = 0; return; end
        CMD_APPEND: begin
          if (npts < MAX_POINTS) begin
            xs[npts] = px; ys[npts] = py; goal_yaw = yaw; npts++;
          end
          return;
        end
        CMD_RESET: begin latched = 0; latched_timeout = 0; timer = 0; return; end
        default: ;
      endcase
      r = '0; r.phase = PH_OUTSIDE; r.speed_limit = '1; r.arc_left = '1;
      herr = 0;
      if (npts > 0) begin
        best = 0;
        best_sq = sq_dist(xs[0], ys[0], px, py);
        for (int i = 1; i < npts; i++) begin
          d = sq_dist(xs[i], ys[i], px, py);
          if (d < best_sq) begin best_sq = d; best = i; end
        end
        r.arc_left = 0;
        for (int i = best + 1; i < npts; i++)
          r.arc_left = sat_add(r.arc_left, root_sat(sq_dist(xs[i], ys[i], xs[i-1], ys[i-1])));
        r.distance_error = root_sat(sq_dist(xs[npts-1], ys[npts-1], px, py));
        herr = int'(goal_yaw) - int'(yaw);
        while (herr > 25736) herr -= 51472;
        while (herr <= -25736) herr += 51472;
        r.heading_error = 16'(herr);
      end
      if (latched) begin
        r.phase = latched_timeout ? PH_TIMEOUT : PH_REACHED;
        r.speed_limit = 0;
        r.align_time = timer;
      end else if (npts == 0 || r.arc_left > band) begin
        timer = 0;
      end else if (r.distance_error > xy_tol) begin
        timer = 0;
        r.phase = PH_APPROACH;
        prod = 66'(decel) * 66'(r.arc_left) * 2;
        r.speed_limit = root_sat(prod);
      end else begin
        mag = herr < 0 ? -herr : herr;
        r.speed_limit = 0;
        if (mag <= head_tol) begin
          timer = 0; latched = 1; latched_timeout = 0; r.phase = PH_REACHED;
        end else begin
          timer = sat_add(timer, 32'(dt));
          r.align_time = timer;
          if (timer > timeout_us) begin
            latched = 1; latched_timeout = 1; r.phase = PH_TIMEOUT;
          end else begin
            r.phase = PH_ALIGN;
            turn = longint'(herr) * 16;
            if (turn > longint'(turn_max)) turn = longint'(turn_max);
            if (turn < -longint'(turn_max)) turn = -longint'(turn_max);
            r.turn_command = 32'(turn);
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        $error("result beat with no report pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.phase < 5) phase_seen[want.phase]++;
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase); errors++;
      end
      if (got.speed_limit !== want.speed_limit) begin
        $error("speed_limit: expected %0h, got %0h", want.speed_limit, got.speed_limit);
        errors++;
      end
      if (got.turn_command !== want.turn_command) begin
        $error("turn_command: expected %0d, got %0d", want.turn_command, got.turn_command);
        errors++;
      end
      if (got.arc_left !== want.arc_left) begin
        $error("arc_left: expected %0h, got %0h", want.arc_left, got.arc_left); errors++;
      end
      if (got.distance_error !== want.distance_error) begin
        $error("distance_error: expected %0h, got %0h", want.distance_error,
               got.distance_error);
        errors++;
      end
      if (got.heading_error !== want.heading_error) begin
        $error("heading_error: expected %0d, got %0d", want.heading_error,
               got.heading_error);
        errors++;
      end
      if (got.align_time !== want.align_time) begin
        $error("align_time: expected %0d, got %0d", want.align_time, got.align_time);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== sim/tb_goal_approach_supervisor.sv =====
// Testbench top: drives commands and config, checks every report beat.
module tb_goal_approach_supervisor;
  import gas_pkg::*;
  import gas_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gas_in_if  in_ch();
  gas_out_if out_ch();

  goal_approach_supervisor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  approach_scoreboard sb = new();
  bit  stim_done = 0;
  int  beats_sent = 0;
  int  burst_left = 0;

  initial begin
    in_ch.valid = 0; in_ch.cmd = CMD_CLEAR; in_ch.pos_x = 0; in_ch.pos_y = 0;
    in_ch.heading = 0; in_ch.dt_us = 1;
    out_ch.ready = 0;
  end

  // Receiver: stall pattern switches between modes, including none at all.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Result beats are sampled at the accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.phase, out_ch.speed_limit, out_ch.turn_command,
                        out_ch.arc_left, out_ch.distance_error, out_ch.heading_error,
                        out_ch.align_time});
  end

  // One input beat; sender sometimes idles between bursts. Valid stays high across
  // back-to-back beats, so it is never lowered and raised in one step.
  task automatic send_beat(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                           logic [15:0] yaw, logic [15:0] dt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1'b1; in_ch.cmd <= cmd; in_ch.pos_x <= px; in_ch.pos_y <= py;
    in_ch.heading <= yaw; in_ch.dt_us <= dt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, px, py, yaw, dt);
    beats_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // non-result commands give no report to wait for
  endtask

  // write enable drops between writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_yaw();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // Small coordinates near the origin so the approach phases are reached.
  function automatic logic [31:0] near(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic build_path(int n, int span, logic [15:0] yaw_end);
    logic [31:0] x, y;
    send_beat(CMD_CLEAR, $urandom, $urandom, 16'($urandom), 16'($urandom));
    x = near(span); y = near(span);
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_APPEND, x, y, (i == n - 1) ? yaw_end : rand_yaw(), 16'($urandom));
      x = x + near(span / 4); y = y + near(span / 4);
    end
  endtask

  initial begin
    logic [31:0] gx, gy;
    logic [15:0] gyaw;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty path, field extremes, full store, latch behavior.
    send_beat(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd25736, 16'd1);
    send_beat(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, -16'sd25736, 16'hFFFF);
    send_beat(CMD_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd25736, 16'd1);
    send_beat(CMD_STEP, 32'h8000_0000, 32'h8000_0000, -16'sd25736, 16'hFFFF);
    send_beat(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd0, 16'd1);
    send_beat(CMD_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16'sd25736, 16'd7);
    send_beat(CMD_RESET, 0, 0, 0, 0);
    send_beat(CMD_CLEAR, 0, 0, 0, 0);
    send_beat(CMD_STEP, 0, 0, 0, 1);
    send_beat(CMD_APPEND, 0, 0, 16'sd100, 0);
    send_beat(CMD_STEP, 0, 0, 16'sd100, 1);          // reached, latched
    send_beat(CMD_CLEAR, 0, 0, 0, 0);
    send_beat(CMD_STEP, 0, 0, 0, 1);                  // latch outranks empty path
    send_beat(CMD_RESET, 0, 0, 0, 0);
    send_beat(CMD_APPEND, 0, 0, 16'sd20000, 0);
    send_beat(CMD_STEP, 0, 0, -16'sd20000, 16'hFFFF); // wraps heading error
    for (int i = 0; i < 256; i++)                     // fill, then overfill
      send_beat(CMD_APPEND, 32'(i * 4096), 0, 16'(i), 0);
    send_beat(CMD_APPEND, 32'h1234_5678, 0, 16'sd999, 0);
    send_beat(CMD_STEP, 0, 0, 0, 1);
    go_idle();

    // Config extremes; timeout reached via a tiny limit over repeated steps.
    write_reg(CFG_XY_TOL, 32'hFFFF_FFFF);
    write_reg(CFG_HEAD_TOL, 32'd1);
    write_reg(CFG_BAND, 32'hFFFF_FFFF);
    write_reg(CFG_DECEL, 32'hFFFF_FFFF);
    write_reg(CFG_TIMEOUT, 32'd1);
    write_reg(CFG_TURN_MAX, 32'h7FFF_FFFF);
    send_beat(CMD_RESET, 0, 0, 0, 0);
    send_beat(CMD_CLEAR, 0, 0, 0, 0);
    send_beat(CMD_APPEND, 0, 0, 16'sd25736, 0);
    send_beat(CMD_STEP, 0, 0, 16'sd0, 16'd1);
    send_beat(CMD_STEP, 0, 0, 16'sd0, 16'd1);
    send_beat(CMD_RESET, 0, 0, 0, 0);
    go_idle();

    // Random phases: several config settings, mostly well-formed sequences.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_XY_TOL, 32'd1); write_reg(CFG_HEAD_TOL, 32'd25735);
          write_reg(CFG_BAND, 32'd1); write_reg(CFG_DECEL, 32'd1);
          write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF); write_reg(CFG_TURN_MAX, 32'd1);
        end
        default: begin
          write_reg(CFG_XY_TOL, $urandom_range(1, 32'h0004_0000));
          write_reg(CFG_HEAD_TOL, $urandom_range(1, 25735));
          write_reg(CFG_BAND, $urandom_range(32'h0001_0000, 32'h0040_0000));
          write_reg(CFG_DECEL, $urandom_range(1, 32'h0100_0000));
          write_reg(CFG_TIMEOUT, $urandom_range(1, 400000));
          write_reg(CFG_TURN_MAX, $urandom_range(1, 32'h0008_0000));
        end
      endcase
      while (beats_sent < 290 + ph * 30) begin
        n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 5);
        gyaw = rand_yaw();
        build_path(n, 32'h0002_0000, gyaw);
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(0, 9))
            0: send_beat(CMD_STEP, $urandom, $urandom, rand_yaw(),
                         16'($urandom_range(1, 65535)));
            1: send_beat(CMD_RESET, $urandom, $urandom, 16'($urandom), 16'($urandom));
            2: send_beat(CMD_APPEND, near(32'h0002_0000), near(32'h0002_0000),
                         rand_yaw(), 16'($urandom));
            default: send_beat(CMD_STEP, near(32'h0003_0000), near(32'h0003_0000),
                               $urandom_range(0, 1) ? rand_yaw() : gyaw + 16'(near(60)),
                               16'($urandom_range(1, 65535)));
          endcase
        end
        if ($urandom_range(0, 2) == 0) send_beat(CMD_RESET, 0, 0, 0, 0);
      end
      go_idle();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    $display("Covered %0d input beats and %0d reports; phases out/appr/align/reach/tmo:",
             beats_sent, sb.checked);
    $display("  %0d/%0d/%0d/%0d/%0d", sb.phase_seen[0], sb.phase_seen[1],
             sb.phase_seen[2], sb.phase_seen[3], sb.phase_seen[4]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/gas_pkg.sv
rtl/gas_in_if.sv
rtl/gas_out_if.sv
rtl/gas_ram.sv
rtl/gas_ctrl.sv
rtl/gas_dp.sv
rtl/goal_approach_supervisor.sv
sim/gas_tb_pkg.sv
sim/tb_goal_approach_supervisor.sv
